// ----- hw/rtl/smx_pkg.sv -----
package smx_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	typedef enum logic [2:0] {
		CMD_PUSH    = 3'd0,
		CMD_POP     = 3'd1,
		CMD_ADD     = 3'd2,
		CMD_SUB     = 3'd3,
		CMD_MUL     = 3'd4,
		CMD_DIV     = 3'd5,
		CMD_PRINT   = 3'd6,
		CMD_UNKNOWN = 3'd7
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_UNKNOWN   = 3'd4,
		ST_HALTED    = 3'd5
	} status_code_t;

	// controller to datapath
	typedef struct packed {
		logic         load_in;
		logic         push;
		logic         rd_top;
		logic         rd_second;
		logic         cap_a;
		logic         cap_b;
		logic         exec;
		logic         div_start;
		logic         wb;
		logic         pop;
		logic         load_out;
		status_code_t status;
		logic         print_en;
	} smx_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_code_t code;
		logic      cnt_zero;
		logic      cnt_lt2;
		logic      cnt_full;
		logic      a_zero;
		logic      div_done;
	} smx_stat_t;

endpackage

// ----- hw/rtl/smx_div.sv -----
module smx_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [smx_pkg::DATA_W-1:0]     dividend,
	input  logic [smx_pkg::DATA_W-1:0]     divisor,
	output logic                           done,
	output logic [smx_pkg::DATA_W-1:0]     quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [smx_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [smx_pkg::DATA_W-1:0]        rem_q;
	logic [smx_pkg::DATA_W-1:0]        quo_q;
	logic [smx_pkg::DATA_W-1:0]        dvs_q;
	logic                              neg_q;
	logic [smx_pkg::DATA_W:0]          rem_shift;
	logic [smx_pkg::DATA_W:0]          diff;
	logic                              nb;
	logic                              na;

	assign nb        = dividend[smx_pkg::DATA_W-1];
	assign na        = divisor[smx_pkg::DATA_W-1];
	assign rem_shift = {rem_q, quo_q[smx_pkg::DATA_W-1]};
	assign diff      = rem_shift - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one quotient bit per cycle, restoring on magnitudes
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= nb ? (smx_pkg::DATA_W'(0) - dividend) : dividend;
			dvs_q <= na ? (smx_pkg::DATA_W'(0) - divisor) : divisor;
			neg_q <= nb ^ na;
			cnt_q <= smx_pkg::DIV_CNT_W'(smx_pkg::DATA_W - 1);
		end else if (busy_q) begin
			rem_q <= diff[smx_pkg::DATA_W] ? rem_shift[smx_pkg::DATA_W-1:0]
				: diff[smx_pkg::DATA_W-1:0];
			quo_q <= {quo_q[smx_pkg::DATA_W-2:0], ~diff[smx_pkg::DATA_W]};
			cnt_q <= cnt_q - smx_pkg::DIV_CNT_W'(1);
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (smx_pkg::DATA_W'(0) - quo_q) : quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

// ----- hw/rtl/smx_dp.sv -----
module smx_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smx_pkg::smx_cmd_t                 cmd,
	output smx_pkg::smx_stat_t                stat,
	input  logic [2:0]                        command,
	input  logic signed [smx_pkg::DATA_W-1:0] operand_value,
	input  logic                              last_of_program,
	output logic [2:0]                        status,
	output logic                              print_valid,
	output logic signed [smx_pkg::DATA_W-1:0] print_value,
	output logic                              program_done
);

	logic [smx_pkg::DATA_W-1:0] mem [smx_pkg::STACK_DEPTH];

	smx_pkg::cmd_code_t           code_q;
	logic [smx_pkg::DATA_W-1:0]   val_q;
	logic                         last_q;
	logic [smx_pkg::CNT_W-1:0]    count_q;
	logic [smx_pkg::DATA_W-1:0]   rdata_q;
	logic [smx_pkg::DATA_W-1:0]   a_q;
	logic [smx_pkg::DATA_W-1:0]   b_q;
	logic [smx_pkg::DATA_W-1:0]   r_q;
	smx_pkg::status_code_t        status_q;
	logic                         print_valid_q;
	logic [smx_pkg::DATA_W-1:0]   print_value_q;
	logic                         program_done_q;

	logic [smx_pkg::CNT_W-1:0]    cnt_m1;
	logic [smx_pkg::CNT_W-1:0]    cnt_m2;
	logic [smx_pkg::PTR_W-1:0]    rd_addr;
	logic [smx_pkg::PTR_W-1:0]    wr_addr;
	logic [smx_pkg::DATA_W-1:0]   wr_data;
	logic                         wr_en;
	logic                         rd_en;
	logic [smx_pkg::DATA_W-1:0]   prod_lo;
	logic                         div_done;
	logic [smx_pkg::DATA_W-1:0]   div_quo;

	assign cnt_m1  = count_q - smx_pkg::CNT_W'(1);
	assign cnt_m2  = count_q - smx_pkg::CNT_W'(2);
	assign rd_en   = cmd.rd_top | cmd.rd_second;
	assign rd_addr = cmd.rd_second ? cnt_m2[smx_pkg::PTR_W-1:0] : cnt_m1[smx_pkg::PTR_W-1:0];
	assign wr_en   = cmd.push | cmd.wb;
	assign wr_addr = cmd.push ? count_q[smx_pkg::PTR_W-1:0] : cnt_m2[smx_pkg::PTR_W-1:0];
	assign wr_data = cmd.push ? val_q : r_q;
	assign prod_lo = a_q * b_q;

	// stack storage, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + smx_pkg::CNT_W'(1);
		end else if (cmd.pop | cmd.wb) begin
			count_q <= cnt_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			code_q <= smx_pkg::cmd_code_t'(command);
			val_q  <= operand_value;
			last_q <= last_of_program;
		end
		if (cmd.cap_a) begin
			a_q <= rdata_q;
		end
		if (cmd.cap_b) begin
			b_q <= rdata_q;
		end
		if (div_done) begin
			r_q <= div_quo;
		end else if (cmd.exec) begin
			case (code_q)
				smx_pkg::CMD_ADD: r_q <= b_q + a_q;
				smx_pkg::CMD_SUB: r_q <= b_q - a_q;
				smx_pkg::CMD_MUL: r_q <= prod_lo;
				default:          r_q <= r_q;
			endcase
		end
		if (cmd.load_out) begin
			status_q       <= cmd.status;
			print_valid_q  <= cmd.print_en;
			print_value_q  <= cmd.print_en ? rdata_q : '0;
			program_done_q <= last_q;
		end
	end

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (b_q),
		.divisor  (a_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign stat.code     = code_q;
	assign stat.cnt_zero = (count_q == '0);
	assign stat.cnt_lt2  = (count_q < smx_pkg::CNT_W'(2));
	assign stat.cnt_full = (count_q == smx_pkg::CNT_W'(smx_pkg::STACK_DEPTH));
	assign stat.a_zero   = (a_q == '0);
	assign stat.div_done = div_done;

	assign status       = status_q;
	assign print_valid  = print_valid_q;
	assign print_value  = print_value_q;
	assign program_done = program_done_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= smx_pkg::CNT_W'(smx_pkg::STACK_DEPTH))
		else $error("stack count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.cnt_full)
		else $error("push on full stack");

endmodule

// ----- hw/rtl/smx_ctrl.sv -----
module smx_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output smx_pkg::smx_cmd_t  cmd,
	input  smx_pkg::smx_stat_t stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_A,
		S_RD_B,
		S_EXEC,
		S_DIVW,
		S_WB,
		S_POP,
		S_FINISH
	} state_t;

	state_t                state_q;
	state_t                state_d;
	logic                  halted_q;
	logic                  out_valid_q;
	smx_pkg::status_code_t status_q;
	logic                  print_q;
	logic                  err;
	smx_pkg::status_code_t err_code;

	// next state, error detection and datapath commands
	always_comb begin
		cmd          = '0;
		cmd.status   = status_q;
		cmd.print_en = print_q;
		state_d      = state_q;
		err          = 1'b0;
		err_code     = smx_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				if (!halted_q) begin
					case (stat.code)
						smx_pkg::CMD_PUSH: begin
							if (stat.cnt_full) begin
								err      = 1'b1;
								err_code = smx_pkg::ST_OVERFLOW;
							end else begin
								cmd.push = 1'b1;
							end
						end
						smx_pkg::CMD_POP, smx_pkg::CMD_PRINT: begin
							if (stat.cnt_zero) begin
								err      = 1'b1;
								err_code = smx_pkg::ST_UNDERFLOW;
							end else begin
								cmd.rd_top = 1'b1;
								state_d    = S_POP;
							end
						end
						smx_pkg::CMD_ADD, smx_pkg::CMD_SUB, smx_pkg::CMD_MUL,
						smx_pkg::CMD_DIV: begin
							if (stat.cnt_lt2) begin
								err      = 1'b1;
								err_code = smx_pkg::ST_UNDERFLOW;
							end else begin
								cmd.rd_top = 1'b1;
								state_d    = S_RD_A;
							end
						end
						default: begin
							err      = 1'b1;
							err_code = smx_pkg::ST_UNKNOWN;
						end
					endcase
				end
			end
			S_RD_A: begin
				cmd.cap_a     = 1'b1;
				cmd.rd_second = 1'b1;
				state_d       = S_RD_B;
			end
			S_RD_B: begin
				cmd.cap_b = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				if (stat.code == smx_pkg::CMD_DIV) begin
					if (stat.a_zero) begin
						err      = 1'b1;
						err_code = smx_pkg::ST_DIVZERO;
						state_d  = S_FINISH;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIVW;
					end
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_WB;
				end
			end
			S_DIVW: begin
				if (stat.div_done) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_FINISH;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= smx_pkg::ST_OK;
			print_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE) begin
				status_q <= smx_pkg::ST_OK;
				print_q  <= 1'b0;
			end
			if (state_q == S_DECODE) begin
				if (halted_q) begin
					status_q <= smx_pkg::ST_HALTED;
				end
				print_q <= !halted_q && (stat.code == smx_pkg::CMD_PRINT) && !stat.cnt_zero;
			end
			if (err) begin
				status_q <= err_code;
				halted_q <= 1'b1;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECODE))
		else $error("accepted transfer not decoded");

endmodule

// ----- hw/rtl/stack_machine_executor.sv -----
// stack machine executor: one instruction per input transfer, one result per instruction
// steps: push, halted or decode-time error end at decode; pop/print read the top, then pop;
// add/sub/mul read both operands, execute, write back; div runs a restoring divider, one bit
// a cycle, then writes back; divide by zero ends after the reads. One instruction at a time;
// the next transfer is taken while a result waits, and its result stalls until that one is taken
// reset: arst_n asynchronous, clears stack count, halt flag and handshake; stack memory kept
module stack_machine_executor (
	input  logic                              clk,
	input  logic                              arst_n,
	// instruction channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        command,
	input  logic signed [smx_pkg::DATA_W-1:0] operand_value,
	input  logic                              last_of_program,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        status,
	output logic                              print_valid,
	output logic signed [smx_pkg::DATA_W-1:0] print_value,
	output logic                              program_done
);

	// command and status bundles between sequencer and datapath
	smx_pkg::smx_cmd_t  cmd;
	smx_pkg::smx_stat_t stat;

	// sequencer: decodes the instruction, checks stack bounds and the halt flag,
	// steps the datapath through reads, execute, divide wait and write-back,
	// then loads the result register once it is free
	smx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// datapath: instruction latch, stack memory with registered read port,
	// stack count, operand registers, adder, multiplier, iterative divider
	// and the result register that parts the two channels
	smx_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.command         (command),
		.operand_value   (operand_value),
		.last_of_program (last_of_program),
		.status          (status),
		.print_valid     (print_valid),
		.print_value     (print_value),
		.program_done    (program_done)
	);

endmodule

// ----- sim/stack_machine_executor_tb.sv -----
module stack_machine_executor_tb;

	localparam int CLK_PERIOD       = 10;
	localparam int TIMEOUT_CYCLES   = 1_000_000;
	localparam int HOLD_OFF_CYCLES  = 400;
	localparam int ITEMS_PER_PHASE  = 250;
	localparam int FILL_PHASE_ITEMS = 20;
	localparam int DRAIN_CYCLES     = 60;
	localparam int HALTED_TAIL      = 24;

	localparam logic [31:0] MIN_WORD = 32'h8000_0000;
	localparam logic [31:0] MAX_WORD = 32'h7fff_ffff;

	// one result transfer, as the block reports it
	typedef struct packed {
		smx_pkg::status_code_t st;
		logic                  pvalid;
		logic [31:0]           pval;
		logic                  done;
	} exec_result_t;

	// what the sender knows about an instruction it offered
	typedef struct packed {
		bit           typed;
		exec_result_t res;
	} offered_instr_t;

	typedef struct packed {
		smx_pkg::cmd_code_t    cmd;
		logic [31:0]           val;
		logic                  last;
		bit                    typed;
		smx_pkg::status_code_t st;
		logic                  pvalid;
		logic [31:0]           pval;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = smx_pkg::CMD_PUSH;
	logic signed [smx_pkg::DATA_W-1:0] operand_value = '0;
	logic        last_of_program = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic        print_valid;
	logic signed [smx_pkg::DATA_W-1:0] print_value;
	logic        program_done;

	// shadow of the machine, advanced on every accepted instruction
	logic [31:0] shadow_stack [smx_pkg::STACK_DEPTH];
	int unsigned shadow_count = 0;
	bit          shadow_halted = 1'b0;

	exec_result_t   queued_outcomes [$];
	offered_instr_t offered_instrs [$];
	int             mismatch_count = 0;

	// idling knobs, percent of cycles
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_off_asked = 0;
	int hold_off_served = 0;

	// stack depth as the generator sees it, ahead of acceptance
	int gen_depth = 0;

	// directed program: extremes, every operation, minimum over minus one,
	// wrapping add/sub/mul; typed rows carry their result
	directed_row_t directed_rows [24] = '{
		'{smx_pkg::CMD_PUSH,  MAX_WORD,      1'b0, 1'b1, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PUSH,  MIN_WORD,      1'b0, 1'b1, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PRINT, 32'h0,         1'b0, 1'b1, smx_pkg::ST_OK, 1'b1, MIN_WORD},
		'{smx_pkg::CMD_PRINT, 32'hffff_ffff, 1'b1, 1'b1, smx_pkg::ST_OK, 1'b1, MAX_WORD},
		'{smx_pkg::CMD_PUSH,  MIN_WORD,      1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PUSH,  32'hffff_ffff, 1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_DIV,   32'h1234_5678, 1'b0, 1'b1, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PRINT, 32'h0,         1'b1, 1'b1, smx_pkg::ST_OK, 1'b1, MIN_WORD},
		'{smx_pkg::CMD_PUSH,  MAX_WORD,      1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PUSH,  32'h1,         1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_ADD,   32'h0,         1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PRINT, 32'h0,         1'b0, 1'b1, smx_pkg::ST_OK, 1'b1, MIN_WORD},
		'{smx_pkg::CMD_PUSH,  MIN_WORD,      1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PUSH,  32'h1,         1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_SUB,   32'h0,         1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PRINT, 32'h0,         1'b1, 1'b1, smx_pkg::ST_OK, 1'b1, MAX_WORD},
		'{smx_pkg::CMD_PUSH,  32'hffff_fff9, 1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PUSH,  32'h2,         1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_DIV,   32'h0,         1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PUSH,  32'h0001_0000, 1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_PUSH,  32'h0001_0000, 1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_MUL,   32'h0,         1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_ADD,   32'h0,         1'b0, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0},
		'{smx_pkg::CMD_POP,   32'h0,         1'b1, 1'b0, smx_pkg::ST_OK, 1'b0, 32'h0}
	};

	stack_machine_executor i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.operand_value   (operand_value),
		.last_of_program (last_of_program),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.print_valid     (print_valid),
		.print_value     (print_value),
		.program_done    (program_done)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// runs one instruction on the shadow machine and gives its result
	task automatic execute_on_shadow(input smx_pkg::cmd_code_t cmd, input logic [31:0] val,
			input logic last, output exec_result_t res);
		logic signed [31:0]    top;
		logic signed [31:0]    second;
		logic [31:0]           r;
		smx_pkg::status_code_t st;
		st = smx_pkg::ST_OK;
		r = '0;
		res.pvalid = 1'b0;
		res.pval = '0;
		res.done = last;
		if (shadow_halted) begin
			st = smx_pkg::ST_HALTED;
		end else begin
			case (cmd)
				smx_pkg::CMD_PUSH: begin
					if (shadow_count >= smx_pkg::STACK_DEPTH) begin
						st = smx_pkg::ST_OVERFLOW;
					end else begin
						shadow_stack[shadow_count] = val;
						shadow_count++;
					end
				end
				smx_pkg::CMD_POP, smx_pkg::CMD_PRINT: begin
					if (shadow_count == 0) begin
						st = smx_pkg::ST_UNDERFLOW;
					end else begin
						shadow_count--;
						if (cmd == smx_pkg::CMD_PRINT) begin
							res.pvalid = 1'b1;
							res.pval = shadow_stack[shadow_count];
						end
					end
				end
				smx_pkg::CMD_ADD, smx_pkg::CMD_SUB, smx_pkg::CMD_MUL, smx_pkg::CMD_DIV: begin
					if (shadow_count < 2) begin
						st = smx_pkg::ST_UNDERFLOW;
					end else begin
						top = shadow_stack[shadow_count - 1];
						second = shadow_stack[shadow_count - 2];
						case (cmd)
							smx_pkg::CMD_ADD: r = second + top;
							smx_pkg::CMD_SUB: r = second - top;
							smx_pkg::CMD_MUL: r = second * top;
							default: begin
								if (top == 0)
									st = smx_pkg::ST_DIVZERO;
								else if (second == MIN_WORD && top == -1)
									r = second; // wraps back to the minimum
								else
									r = second / top;
							end
						endcase
						if (st == smx_pkg::ST_OK) begin
							shadow_count--;
							shadow_stack[shadow_count - 1] = r;
						end
					end
				end
				default: st = smx_pkg::ST_UNKNOWN;
			endcase
		end
		// any error stops the machine until reset
		if (st != smx_pkg::ST_OK && st != smx_pkg::ST_HALTED)
			shadow_halted = 1'b1;
		res.st = st;
	endtask

	// offers one instruction and returns at the edge that accepts it
	task automatic send_instr(input smx_pkg::cmd_code_t cmd, input logic [31:0] val,
			input logic last, input bit typed, input smx_pkg::status_code_t st,
			input logic pvalid, input logic [31:0] pval);
		offered_instr_t tag;
		tag.typed = typed;
		tag.res = '{st, pvalid, pval, last};
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		offered_instrs.push_back(tag);
		in_valid <= 1'b1;
		command <= cmd;
		operand_value <= val;
		last_of_program <= last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// checked by the shadow machine; keeps the generator's depth in step
	task automatic issue(input smx_pkg::cmd_code_t cmd, input logic [31:0] val);
		send_instr(cmd, val, $urandom_range(7) == 0, 1'b0, smx_pkg::ST_OK, 1'b0, '0);
		case (cmd)
			smx_pkg::CMD_PUSH: gen_depth++;
			default:           gen_depth--;
		endcase
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $urandom_range(32) - 32'd16;
			7:          return MIN_WORD;
			8:          return MAX_WORD;
			default:    return ($urandom_range(2) == 0) ? 32'h0 :
				($urandom_range(1) == 0) ? 32'h1 : 32'hffff_ffff;
		endcase
	endfunction

	// transfer monitor: predicts on every accepted instruction, checks every result
	always @(posedge clk) begin
		offered_instr_t tag;
		exec_result_t   want;
		exec_result_t   got;
		if (in_valid && in_ready) begin
			tag = offered_instrs.pop_front();
			execute_on_shadow(smx_pkg::cmd_code_t'(command), operand_value, last_of_program,
				want);
			if (tag.typed)
				want = tag.res;
			queued_outcomes.push_back(want);
		end
		if (out_valid && out_ready) begin
			got = '{smx_pkg::status_code_t'(status), print_valid, print_value, program_done};
			if (queued_outcomes.size() == 0) begin
				$error("result transfer with no instruction outstanding: status %0d", got.st);
				mismatch_count++;
			end else begin
				want = queued_outcomes.pop_front();
				if (got.st !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, got.st);
					mismatch_count++;
				end
				if (got.pvalid !== want.pvalid) begin
					$error("print_valid: expected %0d, actual %0d", want.pvalid, got.pvalid);
					mismatch_count++;
				end
				if (got.pval !== want.pval) begin
					$error("print_value: expected %h, actual %h", want.pval, got.pval);
					mismatch_count++;
				end
				if (got.done !== want.done) begin
					$error("program_done: expected %0d, actual %0d", want.done, got.done);
					mismatch_count++;
				end
			end
		end
	end

	// result side: random stalls, plus a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_served != hold_off_asked) begin
				hold_off_served++;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int          r;
		int          push_w;
		int          err_kind;
		int          phase_items;
		logic [31:0] divisor;
		directed_row_t row;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed program
		for (int i = 0; i < $size(directed_rows); i++) begin
			row = directed_rows[i];
			send_instr(row.cmd, row.val, row.last, row.typed, row.st, row.pvalid, row.pval);
		end

		// the closing error is picked first; an overflow run spends its items on the fill
		err_kind = $urandom_range(3);
		phase_items = (err_kind == 0) ? FILL_PHASE_ITEMS : ITEMS_PER_PHASE;

		// random well-formed programs, one idling pattern per phase
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
					hold_off_asked++; // result side stops, instructions keep coming
				end
				1: begin
					tx_idle_pct = 71;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 71;
				end
				default: begin
					tx_idle_pct = 32;
					rx_stall_pct = 32;
				end
			endcase
			for (int n = 0; n < phase_items; n++) begin
				r = $urandom_range(99);
				push_w = (gen_depth < 4) ? 60 : (gen_depth < 32) ? 40 : 25;
				if (gen_depth == 0 || r < push_w) begin
					issue(smx_pkg::CMD_PUSH, rand_operand());
				end else if (gen_depth == 1) begin
					issue(($urandom_range(1) == 0) ? smx_pkg::CMD_POP : smx_pkg::CMD_PRINT,
						$urandom);
				end else begin
					case ($urandom_range(5))
						0: issue(smx_pkg::CMD_POP, $urandom);
						1: issue(smx_pkg::CMD_PRINT, $urandom);
						2: issue(smx_pkg::CMD_ADD, $urandom);
						3: issue(smx_pkg::CMD_SUB, $urandom);
						4: issue(smx_pkg::CMD_MUL, $urandom);
						default: begin
							// fresh nonzero divisor on top keeps the machine running
							do
								divisor = rand_operand();
							while (divisor == 0);
							issue(smx_pkg::CMD_PUSH, divisor);
							issue(smx_pkg::CMD_DIV, $urandom);
						end
					endcase
				end
			end
		end

		// one error, then the halted machine
		case (err_kind)
			0: begin
				// full stack, then a push that overflows
				while (gen_depth < smx_pkg::STACK_DEPTH)
					issue(smx_pkg::CMD_PUSH, rand_operand());
				issue(smx_pkg::CMD_SUB, $urandom);
				issue(smx_pkg::CMD_PUSH, rand_operand());
				send_instr(smx_pkg::CMD_PUSH, $urandom, 1'b0, 1'b1, smx_pkg::ST_OVERFLOW,
					1'b0, '0);
			end
			1: begin
				while (gen_depth > 0)
					issue(smx_pkg::CMD_PRINT, $urandom);
				send_instr(smx_pkg::cmd_code_t'($urandom_range(6, 1)), $urandom, 1'b1, 1'b1,
					smx_pkg::ST_UNDERFLOW, 1'b0, '0);
			end
			2: begin
				issue(smx_pkg::CMD_PUSH, rand_operand());
				issue(smx_pkg::CMD_PUSH, 32'h0);
				send_instr(smx_pkg::CMD_DIV, $urandom, 1'b0, 1'b1, smx_pkg::ST_DIVZERO,
					1'b0, '0);
			end
			default: send_instr(smx_pkg::CMD_UNKNOWN, $urandom, 1'b0, 1'b1,
				smx_pkg::ST_UNKNOWN, 1'b0, '0);
		endcase
		send_instr(smx_pkg::CMD_UNKNOWN, $urandom, 1'b1, 1'b1, smx_pkg::ST_HALTED, 1'b0, '0);
		for (int n = 0; n < HALTED_TAIL; n++) begin
			r = $urandom_range(1);
			send_instr(smx_pkg::cmd_code_t'($urandom_range(7)), $urandom, r[0], 1'b1,
				smx_pkg::ST_HALTED, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// wait for every result, then a little longer for strays
		while (queued_outcomes.size() != 0 || offered_instrs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/smx_pkg.sv
hw/rtl/smx_div.sv
hw/rtl/smx_dp.sv
hw/rtl/smx_ctrl.sv
hw/rtl/stack_machine_executor.sv
sim/stack_machine_executor_tb.sv
